// ----- hw/rtl/rc2_pkg.sv -----
package rc2_pkg;

  typedef logic [15:0] word_t;
  typedef logic [7:0]  kbyte_t;
  typedef logic [3:0]  uaddr_t;
  typedef logic [6:0]  ucnt_t;

  // datapath operations, one per microinstruction
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MIX,
    OP_MASH,
    OP_OUT,
    OP_KLOAD,
    OP_KFWD,
    OP_KFIX,
    OP_KBWD,
    OP_KDONE
  } op_t;

  // sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_LOOP,
    C_KEY,
    C_ITEM,
    C_OUTFREE,
    C_JUMP
  } cond_t;

  typedef struct packed {
    op_t    op;
    cond_t  cond;
    uaddr_t target;
    ucnt_t  lim;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    op_t   op;
    ucnt_t cnt;
    logic  fire;
  } ctrl_t;

  // top level to sequencer
  typedef struct packed {
    logic key_pend;
    logic in_take;
    logic out_free;
  } stat_t;

  localparam uaddr_t UA_IDLE   = 4'd0;
  localparam uaddr_t UA_ACCEPT = 4'd1;
  localparam uaddr_t UA_MIX_A  = 4'd2;
  localparam uaddr_t UA_MASH_A = 4'd3;
  localparam uaddr_t UA_MIX_B  = 4'd4;
  localparam uaddr_t UA_MASH_B = 4'd5;
  localparam uaddr_t UA_MIX_C  = 4'd6;
  localparam uaddr_t UA_OUT    = 4'd7;
  localparam uaddr_t UA_KLOAD  = 4'd8;
  localparam uaddr_t UA_KFWD   = 4'd9;
  localparam uaddr_t UA_KFIX   = 4'd10;
  localparam uaddr_t UA_KBWD   = 4'd11;
  localparam uaddr_t UA_KDONE  = 4'd12;

  localparam int unsigned SUBKEYS = 64;
  localparam int unsigned SK_AW   = 6;

  localparam kbyte_t PI_TABLE [256] = '{
    8'hd9, 8'h78, 8'hf9, 8'hc4, 8'h19, 8'hdd, 8'hb5, 8'hed,
    8'h28, 8'he9, 8'hfd, 8'h79, 8'h4a, 8'ha0, 8'hd8, 8'h9d,
    8'hc6, 8'h7e, 8'h37, 8'h83, 8'h2b, 8'h76, 8'h53, 8'h8e,
    8'h62, 8'h4c, 8'h64, 8'h88, 8'h44, 8'h8b, 8'hfb, 8'ha2,
    8'h17, 8'h9a, 8'h59, 8'hf5, 8'h87, 8'hb3, 8'h4f, 8'h13,
    8'h61, 8'h45, 8'h6d, 8'h8d, 8'h09, 8'h81, 8'h7d, 8'h32,
    8'hbd, 8'h8f, 8'h40, 8'heb, 8'h86, 8'hb7, 8'h7b, 8'h0b,
    8'hf0, 8'h95, 8'h21, 8'h22, 8'h5c, 8'h6b, 8'h4e, 8'h82,
    8'h54, 8'hd6, 8'h65, 8'h93, 8'hce, 8'h60, 8'hb2, 8'h1c,
    8'h73, 8'h56, 8'hc0, 8'h14, 8'ha7, 8'h8c, 8'hf1, 8'hdc,
    8'h12, 8'h75, 8'hca, 8'h1f, 8'h3b, 8'hbe, 8'he4, 8'hd1,
    8'h42, 8'h3d, 8'hd4, 8'h30, 8'ha3, 8'h3c, 8'hb6, 8'h26,
    8'h6f, 8'hbf, 8'h0e, 8'hda, 8'h46, 8'h69, 8'h07, 8'h57,
    8'h27, 8'hf2, 8'h1d, 8'h9b, 8'hbc, 8'h94, 8'h43, 8'h03,
    8'hf8, 8'h11, 8'hc7, 8'hf6, 8'h90, 8'hef, 8'h3e, 8'he7,
    8'h06, 8'hc3, 8'hd5, 8'h2f, 8'hc8, 8'h66, 8'h1e, 8'hd7,
    8'h08, 8'he8, 8'hea, 8'hde, 8'h80, 8'h52, 8'hee, 8'hf7,
    8'h84, 8'haa, 8'h72, 8'hac, 8'h35, 8'h4d, 8'h6a, 8'h2a,
    8'h96, 8'h1a, 8'hd2, 8'h71, 8'h5a, 8'h15, 8'h49, 8'h74,
    8'h4b, 8'h9f, 8'hd0, 8'h5e, 8'h04, 8'h18, 8'ha4, 8'hec,
    8'hc2, 8'he0, 8'h41, 8'h6e, 8'h0f, 8'h51, 8'hcb, 8'hcc,
    8'h24, 8'h91, 8'haf, 8'h50, 8'ha1, 8'hf4, 8'h70, 8'h39,
    8'h99, 8'h7c, 8'h3a, 8'h85, 8'h23, 8'hb8, 8'hb4, 8'h7a,
    8'hfc, 8'h02, 8'h36, 8'h5b, 8'h25, 8'h55, 8'h97, 8'h31,
    8'h2d, 8'h5d, 8'hfa, 8'h98, 8'he3, 8'h8a, 8'h92, 8'hae,
    8'h05, 8'hdf, 8'h29, 8'h10, 8'h67, 8'h6c, 8'hba, 8'hc9,
    8'hd3, 8'h00, 8'he6, 8'hcf, 8'he1, 8'h9e, 8'ha8, 8'h2c,
    8'h63, 8'h16, 8'h01, 8'h3f, 8'h58, 8'he2, 8'h89, 8'ha9,
    8'h0d, 8'h38, 8'h34, 8'h1b, 8'hab, 8'h33, 8'hff, 8'hb0,
    8'hbb, 8'h48, 8'h0c, 8'h5f, 8'hb9, 8'hb1, 8'hcd, 8'h2e,
    8'hc5, 8'hf3, 8'hdb, 8'h47, 8'he5, 8'ha5, 8'h9c, 8'h77,
    8'h0a, 8'ha6, 8'h20, 8'h68, 8'hfe, 8'h7f, 8'hc1, 8'had
  };

  // rotate left by 1, 2, 3 or 5 depending on word position
  function automatic word_t rol_word(input word_t w, input logic [1:0] pos);
    word_t r;
    case (pos)
      2'd0:    r = {w[14:0], w[15]};
      2'd1:    r = {w[13:0], w[15:14]};
      2'd2:    r = {w[12:0], w[15:13]};
      default: r = {w[10:0], w[15:11]};
    endcase
    return r;
  endfunction

  // microprogram rom
  function automatic uword_t ucode(input uaddr_t addr);
    uword_t u;
    case (addr)
      UA_IDLE:   u = '{OP_NOP,    C_KEY,     UA_KLOAD, 7'd0};
      UA_ACCEPT: u = '{OP_ACCEPT, C_ITEM,    UA_IDLE,  7'd0};
      UA_MIX_A:  u = '{OP_MIX,    C_LOOP,    UA_IDLE,  7'd19};
      UA_MASH_A: u = '{OP_MASH,   C_LOOP,    UA_IDLE,  7'd7};
      UA_MIX_B:  u = '{OP_MIX,    C_LOOP,    UA_IDLE,  7'd23};
      UA_MASH_B: u = '{OP_MASH,   C_LOOP,    UA_IDLE,  7'd7};
      UA_MIX_C:  u = '{OP_MIX,    C_LOOP,    UA_IDLE,  7'd19};
      UA_OUT:    u = '{OP_OUT,    C_OUTFREE, UA_IDLE,  7'd0};
      UA_KLOAD:  u = '{OP_KLOAD,  C_NEXT,    UA_IDLE,  7'd0};
      UA_KFWD:   u = '{OP_KFWD,   C_LOOP,    UA_IDLE,  7'd119};
      UA_KFIX:   u = '{OP_KFIX,   C_NEXT,    UA_IDLE,  7'd0};
      UA_KBWD:   u = '{OP_KBWD,   C_LOOP,    UA_IDLE,  7'd127};
      UA_KDONE:  u = '{OP_KDONE,  C_JUMP,    UA_IDLE,  7'd0};
      default:   u = '{OP_NOP,    C_JUMP,    UA_IDLE,  7'd0};
    endcase
    return u;
  endfunction

endpackage

// ----- hw/rtl/rc2_block_encrypt_core.sv -----
// rc2 encryption core, 8-byte key with 64 effective key bits. a write on the
// cfg port stores the key and marks the 64 x 16 subkey table stale; the table
// is rebuilt (load, 120 forward pi steps, one fixup, 128 backward steps that
// stream subkeys into the table, one done step) before the next block is
// taken, and after reset the all-zero key is expanded the same way. a key
// written while an expansion runs starts a fresh expansion once it ends.
// each block then runs 16 mixing rounds with two mashes between them under
// control of a small microprogram: accept, mix, mash, mix, mash, mix, then
// writeback into the result register, which waits until that register is
// free. each mash word takes a fetch step and an add step because its
// subkey address comes from the word written one step earlier and the subkey
// table has a registered read port. one block is worked at a time; the
// result register lets the next block start while the previous one waits.
module rc2_block_encrypt_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_cipher_key,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plaintext,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_ciphertext
);
  import rc2_pkg::*;

  logic [63:0] key_r;
  logic        key_pend_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  ctrl_t       ctrl;
  stat_t       st;
  logic [63:0] block;
  logic        in_take;
  logic        out_free;
  logic        out_load;

  // an input word is only taken once the subkeys match the stored key
  assign in_ready = (ctrl.op == OP_ACCEPT) && !key_pend_r;
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (ctrl.op == OP_OUT) && ctrl.fire;

  assign st = '{key_pend: key_pend_r, in_take: in_take, out_free: out_free};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      key_pend_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // the stale mark drops when the key is copied into the expander,
      // a fresh key write wins over that copy
      if (cfg_wr_en) begin
        key_r      <= cfg_cipher_key;
        key_pend_r <= 1'b1;
      end else if (ctrl.op == OP_KLOAD) begin
        key_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) begin
      out_data_r <= block;
    end
  end

  rc2_useq u_useq (
    .clk  (clk),
    .rst_n(rst_n),
    .st   (st),
    .ctrl (ctrl)
  );

  rc2_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .key      (key_r),
    .plaintext(in_plaintext),
    .block    (block)
  );

  assign out_valid      = out_valid_r;
  assign out_ciphertext = out_data_r;

  // one block in flight: no second word right after a take
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ready)
    else $error("input taken twice in a row");
  // writeback always lands in the result register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && out_data_r == $past(block)))
    else $error("result word lost at writeback");
  // key load clears the stale mark unless a new key came in
  a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_KLOAD && !cfg_wr_en) |=> !key_pend_r)
    else $error("subkeys still marked stale after key load");

endmodule

// ----- hw/rtl/rc2_ram.sv -----
module rc2_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rc2_useq.sv -----
module rc2_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  rc2_pkg::stat_t st,
  output rc2_pkg::ctrl_t ctrl
);
  import rc2_pkg::*;

  uaddr_t pc_r, pc_nxt;
  ucnt_t  cnt_r, cnt_nxt;
  uword_t uw;
  logic   fire;

  assign uw = ucode(pc_r);

  always_comb begin
    pc_nxt  = pc_r;
    cnt_nxt = '0;
    fire    = 1'b0;
    case (uw.cond)
      C_NEXT: begin
        pc_nxt = pc_r + 4'd1;
      end
      C_LOOP: begin
        if (cnt_r != uw.lim) begin
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          pc_nxt = pc_r + 4'd1;
        end
      end
      C_KEY: begin
        pc_nxt = st.key_pend ? uw.target : pc_r + 4'd1;
      end
      C_ITEM: begin
        if (st.in_take) begin
          fire   = 1'b1;
          pc_nxt = pc_r + 4'd1;
        end else begin
          pc_nxt = uw.target;
        end
      end
      C_OUTFREE: begin
        if (st.out_free) begin
          fire   = 1'b1;
          pc_nxt = uw.target;
        end
      end
      C_JUMP: begin
        pc_nxt = uw.target;
      end
      default: begin
        pc_nxt = UA_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= UA_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign ctrl = '{op: uw.op, cnt: cnt_r, fire: fire};

  // loop counter only runs inside a looping step and never passes its limit
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.cond != C_LOOP) |-> (cnt_r == '0))
    else $error("loop counter nonzero outside a loop");
  a_cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.cond == C_LOOP) |-> (cnt_r <= uw.lim))
    else $error("loop counter past limit");
  a_cnt_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.cond == C_LOOP && cnt_r == uw.lim) |=> (cnt_r == '0))
    else $error("loop counter not cleared at loop exit");

endmodule

// ----- hw/rtl/rc2_dpath.sv -----
module rc2_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  rc2_pkg::ctrl_t ctrl,
  input  logic [63:0]    key,
  input  logic [63:0]    plaintext,
  output logic [63:0]    block
);
  import rc2_pkg::*;

  logic [3:0][15:0] wd_r, wd_nxt;
  logic [7:0][7:0]  win_r, win_nxt;
  kbyte_t           hi_r, hi_nxt;
  logic [SK_AW-1:0] kidx_r, kidx_nxt;

  logic             sk_we;
  logic [SK_AW-1:0] sk_waddr, sk_raddr;
  word_t            sk_wdata, sk_rdata;

  word_t  mix_f, mix_sum, new_word;
  kbyte_t fwd_byte, bwd_byte;

  // mix: current word sits at slot 0, its three predecessors at slots 3, 2, 1
  assign mix_f    = (wd_r[3] & wd_r[2]) + (~wd_r[3] & wd_r[1]);
  assign mix_sum  = wd_r[0] + sk_rdata + mix_f;
  assign fwd_byte = PI_TABLE[win_r[7] + win_r[0]];
  assign bwd_byte = PI_TABLE[win_r[0] ^ win_r[7]];

  always_comb begin
    wd_nxt   = wd_r;
    win_nxt  = win_r;
    hi_nxt   = hi_r;
    kidx_nxt = kidx_r;
    new_word = rol_word(mix_sum, ctrl.cnt[1:0]);
    sk_we    = 1'b0;
    sk_waddr = ~ctrl.cnt[6:1];
    sk_wdata = {hi_r, win_r[7]};
    sk_raddr = kidx_r;
    case (ctrl.op)
      OP_NOP: begin
        kidx_nxt = '0;
      end
      OP_ACCEPT: begin
        if (ctrl.fire) begin
          wd_nxt = plaintext;
        end
      end
      OP_MIX: begin
        wd_nxt   = {new_word, wd_r[3:1]};
        kidx_nxt = kidx_r + 6'd1;
        sk_raddr = kidx_r + 6'd1;
      end
      OP_MASH: begin
        // even count fetches the indexed subkey, odd count adds it
        if (!ctrl.cnt[0]) begin
          sk_raddr = wd_r[3][SK_AW-1:0];
        end else begin
          wd_nxt = {wd_r[0] + sk_rdata, wd_r[3:1]};
        end
      end
      OP_KLOAD: begin
        win_nxt = key;
      end
      OP_KFWD: begin
        win_nxt = {fwd_byte, win_r[7:1]};
      end
      OP_KFIX: begin
        win_nxt[0] = PI_TABLE[win_r[0]];
      end
      OP_KBWD: begin
        // bytes leave from the top, highest index first, two per subkey
        win_nxt = {win_r[6:0], bwd_byte};
        if (ctrl.cnt[0]) begin
          sk_we = 1'b1;
        end else begin
          hi_nxt = win_r[7];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kidx_r <= '0;
    end else begin
      kidx_r <= kidx_nxt;
    end
    wd_r  <= wd_nxt;
    win_r <= win_nxt;
    hi_r  <= hi_nxt;
  end

  rc2_ram #(
    .WIDTH(16),
    .DEPTH(SUBKEYS)
  ) u_subkeys (
    .clk  (clk),
    .we   (sk_we),
    .waddr(sk_waddr),
    .wdata(sk_wdata),
    .raddr(sk_raddr),
    .rdata(sk_rdata)
  );

  assign block = wd_r;

endmodule
